FILE: rtl/source_lexer_core_macros.svh
// assertion macros used by the token queue module
// no dependencies
`ifndef SOURCE_LEXER_CORE_MACROS_SVH
`define SOURCE_LEXER_CORE_MACROS_SVH
`define SLX_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lexer check failed");
`define SLX_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lexer check failed");
`endif

FILE: rtl/slx_pkg.sv
// types and constants of the source lexer
// no dependencies
`timescale 1ns / 1ps
package slx_pkg;
   localparam int KindBits = 6;
   localparam int ErrBits = 2;
   localparam logic [5:0] K_LPAREN = 6'd0, K_RPAREN = 6'd1, K_LBRACE = 6'd2, K_RBRACE = 6'd3,
      K_COMMA = 6'd4, K_DOT = 6'd5, K_MINUS = 6'd6, K_PLUS = 6'd7, K_SEMI = 6'd8,
      K_SLASH = 6'd9, K_STAR = 6'd10, K_BANG = 6'd11, K_EQUAL = 6'd13, K_GREATER = 6'd15,
      K_LESS = 6'd17, K_IDENT = 6'd19, K_STRING = 6'd20, K_NUMBER = 6'd21,
      K_KEYWORD0 = 6'd22, K_END = 6'd38;
   localparam logic [1:0] E_NONE = 2'd0, E_UNEXPECTED = 2'd1, E_UNTERMINATED = 2'd2;
   typedef enum logic [3:0] {
      M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_COMMENT, M_STRING,
      M_INT, M_DOT, M_FRAC, M_WORD
   } mode_type;
   // keyword text, right aligned, 8 chars max
   typedef logic [63:0] kw_word_type;
   localparam kw_word_type KW_TEXT [16] = '{
      64'h616e64, 64'h636c617373, 64'h656c7365, 64'h66616c7365, 64'h66756e, 64'h666f72,
      64'h6966, 64'h6e696c, 64'h6f72, 64'h7072696e74, 64'h72657475726e, 64'h7375706572,
      64'h74686973, 64'h74727565, 64'h766172, 64'h7768696c65};
   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_alp(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction
endpackage

FILE: rtl/slx_if.sv
// valid/ready channel interfaces for the lexer
// depends on slx_pkg
`timescale 1ns / 1ps
interface slx_req_if;
   logic valid;
   logic ready;
   logic [7:0] source_byte;
   logic has_byte;
   logic end_of_source;
   modport source (output valid, source_byte, has_byte, end_of_source, input ready);
   modport sink (input valid, source_byte, has_byte, end_of_source, output ready);
endinterface

interface slx_rsp_if #(parameter int OFFSET_BITS = 20, parameter int LINE_BITS = 16);
   logic valid;
   logic ready;
   logic [slx_pkg::KindBits-1:0] token_kind;
   logic [OFFSET_BITS-1:0] start_offset;
   logic [OFFSET_BITS-1:0] lexeme_length;
   logic [LINE_BITS-1:0] line_number;
   logic [slx_pkg::ErrBits-1:0] error_code;
   logic last_result;
   modport source (output valid, token_kind, start_offset, lexeme_length, line_number,
      error_code, last_result, input ready);
   modport sink (input valid, token_kind, start_offset, lexeme_length, line_number,
      error_code, last_result, output ready);
endinterface

FILE: rtl/source_lexer_core.sv
// source lexer top level: scan front, token queue back
// tokens are registered into the queue when the transaction that ends them is accepted
// throughput: one byte per cycle while the queue has room for four tokens
// each accepted transaction emits 0 to 4 tokens; back drains one token per cycle while rsp.ready is high
// reset: synchronous, active high, clears scan state, counters and queue
`timescale 1ns / 1ps
module source_lexer_core #(
   parameter int OFFSET_BITS = 20,
   parameter int LINE_BITS = 16,
   parameter int KEYWORD_CHARS = 6
) (
   input logic clock,
   input logic reset,
   slx_req_if.sink req,
   slx_rsp_if.source rsp
);
   localparam int RW = slx_pkg::KindBits + 2*OFFSET_BITS + LINE_BITS + slx_pkg::ErrBits;
   logic step, room;
   logic [2:0] n_tok;
   logic [3:0][RW-1:0] toks;
   logic [RW:0] head;

   // a transaction is taken whenever the queue can hold a worst-case burst
   assign req.ready = room;
   assign step = req.valid && req.ready;

   slx_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
      .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
      .clock(clock), .reset(reset), .step(step), .c(req.source_byte),
      .has_byte(req.has_byte), .eos(req.end_of_source), .n_out(n_tok), .res_out(toks));

   slx_back #(.RW(RW)) u_back (
      .clock(clock), .reset(reset), .push(step), .n_in(n_tok), .res_in(toks),
      .room(room), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(head));

   // unpack the queue head into result fields
   assign {rsp.token_kind, rsp.start_offset, rsp.lexeme_length, rsp.line_number,
      rsp.error_code, rsp.last_result} = head;
endmodule

FILE: rtl/slx_front.sv
// front: scan state, classifies each byte into up to four tokens
// depends on slx_pkg
`timescale 1ns / 1ps
module slx_front #(
   parameter int OFFSET_BITS = 20,
   parameter int LINE_BITS = 16,
   parameter int KEYWORD_CHARS = 6,
   localparam int RW = slx_pkg::KindBits + 2*OFFSET_BITS + LINE_BITS + slx_pkg::ErrBits
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [7:0] c,
   input  logic has_byte,
   input  logic eos,
   output logic [2:0] n_out,
   output logic [3:0][RW-1:0] res_out
);
   localparam int WB = 8*KEYWORD_CHARS;
   localparam logic [OFFSET_BITS-1:0] OffMax = '1;
   localparam logic [LINE_BITS-1:0] LineMax = '1;
   slx_pkg::mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [WB-1:0] word_ff, word_in;
   logic long_ff, long_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= slx_pkg::M_IDLE;
         pos_ff <= '0;
         start_ff <= '0;
         line_ff <= LINE_BITS'(1);
         word_ff <= '0;
         long_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         line_ff <= line_in;
         word_ff <= word_in;
         long_ff <= long_in;
      end
   end

   function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] f,
                                                   input logic [OFFSET_BITS-1:0] t);
      return (t >= f) ? t - f : '0;
   endfunction

   function automatic logic [5:0] word_kind(input logic [WB-1:0] w, input logic lg);
      logic [5:0] k;
      k = slx_pkg::K_IDENT;
      if (!lg)
         for (int i = 0; i < 16; i++)
            if (64'(w) == slx_pkg::KW_TEXT[i]) k = slx_pkg::K_KEYWORD0 + 6'(i);
      return k;
   endfunction

   function automatic logic [5:0] op_base(input slx_pkg::mode_type m);
      logic [5:0] k;
      unique case (m)
         slx_pkg::M_BANG: k = slx_pkg::K_BANG;
         slx_pkg::M_EQUAL: k = slx_pkg::K_EQUAL;
         slx_pkg::M_LESS: k = slx_pkg::K_LESS;
         default: k = slx_pkg::K_GREATER;
      endcase
      return k;
   endfunction

   always_comb begin
      logic [OFFSET_BITS-1:0] dot, st;
      logic fresh, wl;
      logic [LINE_BITS-1:0] nl;
      logic [5:0] pk;
      logic [1:0] pe;
      mode_in = mode_ff;
      start_in = start_ff;
      line_in = line_ff;
      word_in = word_ff;
      long_in = long_ff;
      n_out = '0;
      res_out = '0;
      fresh = 1'b0;
      pk = slx_pkg::K_LPAREN;
      pe = slx_pkg::E_NONE;
      dot = (pos_ff != '0) ? pos_ff - 1'b1 : '0;
      nl = (line_ff != LineMax) ? line_ff + 1'b1 : line_ff;
      st = start_ff;
      wl = long_ff;
      if (has_byte) begin
         unique case (mode_ff)
            slx_pkg::M_BANG, slx_pkg::M_EQUAL, slx_pkg::M_LESS, slx_pkg::M_GREATER: begin
               if (c == "=") begin
                  res_out[n_out[1:0]] = {op_base(mode_ff) + 6'd1, st, span(st, pos_ff) + 1'b1,
                     line_ff, slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  mode_in = slx_pkg::M_IDLE;
               end else begin
                  res_out[n_out[1:0]] = {op_base(mode_ff), st, OFFSET_BITS'(1), line_ff,
                     slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  fresh = 1'b1;
               end
            end
            slx_pkg::M_SLASH: begin
               if (c == "/") mode_in = slx_pkg::M_COMMENT;
               else begin
                  res_out[n_out[1:0]] = {slx_pkg::K_SLASH, st, OFFSET_BITS'(1), line_ff,
                     slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  fresh = 1'b1;
               end
            end
            slx_pkg::M_COMMENT: begin
               if (c == 8'h0a) begin
                  line_in = nl;
                  mode_in = slx_pkg::M_IDLE;
               end
            end
            slx_pkg::M_STRING: begin
               if (c == "\"") begin
                  res_out[n_out[1:0]] = {slx_pkg::K_STRING, st, span(st, pos_ff) + 1'b1,
                     line_ff, slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  mode_in = slx_pkg::M_IDLE;
               end else if (c == 8'h0a) line_in = nl;
            end
            slx_pkg::M_INT: begin
               if (c == ".") mode_in = slx_pkg::M_DOT;
               else if (!slx_pkg::is_dig(c)) begin
                  res_out[n_out[1:0]] = {slx_pkg::K_NUMBER, st, span(st, pos_ff), line_ff,
                     slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  fresh = 1'b1;
               end
            end
            slx_pkg::M_DOT: begin
               if (slx_pkg::is_dig(c)) mode_in = slx_pkg::M_FRAC;
               else begin
                  res_out[0] = {slx_pkg::K_NUMBER, st, span(st, dot), line_ff, slx_pkg::E_NONE};
                  res_out[1] = {slx_pkg::K_DOT, dot, OFFSET_BITS'(1), line_ff, slx_pkg::E_NONE};
                  n_out = 3'd2;
                  fresh = 1'b1;
               end
            end
            slx_pkg::M_FRAC: begin
               if (!slx_pkg::is_dig(c)) begin
                  res_out[n_out[1:0]] = {slx_pkg::K_NUMBER, st, span(st, pos_ff), line_ff,
                     slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  fresh = 1'b1;
               end
            end
            slx_pkg::M_WORD: begin
               if (slx_pkg::is_dig(c) || slx_pkg::is_alp(c)) begin
                  if (word_ff[WB-1 -: 8] != 8'd0) long_in = 1'b1;
                  word_in = {word_ff[WB-9:0], c};
               end else begin
                  res_out[n_out[1:0]] = {word_kind(word_ff, long_ff), st, span(st, pos_ff),
                     line_ff, slx_pkg::E_NONE};
                  n_out = n_out + 3'd1;
                  fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase
         if (fresh) begin
            start_in = pos_ff;
            mode_in = slx_pkg::M_IDLE;
            unique case (c)
               "(": pk = slx_pkg::K_LPAREN;
               ")": pk = slx_pkg::K_RPAREN;
               "{": pk = slx_pkg::K_LBRACE;
               "}": pk = slx_pkg::K_RBRACE;
               ",": pk = slx_pkg::K_COMMA;
               ".": pk = slx_pkg::K_DOT;
               "-": pk = slx_pkg::K_MINUS;
               "+": pk = slx_pkg::K_PLUS;
               ";": pk = slx_pkg::K_SEMI;
               "*": pk = slx_pkg::K_STAR;
               default: pe = slx_pkg::E_UNEXPECTED;
            endcase
            res_out[n_out[1:0]] = {pk, pos_ff, OFFSET_BITS'(1), line_ff, pe};
            priority if (c == "(" || c == ")" || c == "{" || c == "}" || c == "," || c == "."
                  || c == "-" || c == "+" || c == ";" || c == "*") n_out = n_out + 3'd1;
            else if (c == "!") mode_in = slx_pkg::M_BANG;
            else if (c == "=") mode_in = slx_pkg::M_EQUAL;
            else if (c == "<") mode_in = slx_pkg::M_LESS;
            else if (c == ">") mode_in = slx_pkg::M_GREATER;
            else if (c == "/") mode_in = slx_pkg::M_SLASH;
            else if (c == "\"") mode_in = slx_pkg::M_STRING;
            else if (c == " " || c == 8'h0d || c == 8'h09) mode_in = slx_pkg::M_IDLE;
            else if (c == 8'h0a) line_in = nl;
            else if (slx_pkg::is_dig(c)) mode_in = slx_pkg::M_INT;
            else if (slx_pkg::is_alp(c)) begin
               mode_in = slx_pkg::M_WORD;
               word_in = {{(WB-8){1'b0}}, c};
               long_in = 1'b0;
            end else n_out = n_out + 3'd1;
         end
      end
      pos_in = (has_byte && pos_ff != OffMax) ? pos_ff + 1'b1 : pos_ff;
      if (eos) begin
         // finish on updated state, then the end token
         st = start_in;
         dot = (pos_in != '0) ? pos_in - 1'b1 : '0;
         unique case (mode_in)
            slx_pkg::M_BANG, slx_pkg::M_EQUAL, slx_pkg::M_LESS, slx_pkg::M_GREATER: begin
               res_out[n_out[1:0]] = {op_base(mode_in), st, OFFSET_BITS'(1), line_in,
                  slx_pkg::E_NONE};
               n_out = n_out + 3'd1;
            end
            slx_pkg::M_SLASH: begin
               res_out[n_out[1:0]] = {slx_pkg::K_SLASH, st, OFFSET_BITS'(1), line_in,
                  slx_pkg::E_NONE};
               n_out = n_out + 3'd1;
            end
            slx_pkg::M_STRING: begin
               res_out[n_out[1:0]] = {slx_pkg::K_LPAREN, st, span(st, pos_in), line_in,
                  slx_pkg::E_UNTERMINATED};
               n_out = n_out + 3'd1;
            end
            slx_pkg::M_INT, slx_pkg::M_FRAC: begin
               res_out[n_out[1:0]] = {slx_pkg::K_NUMBER, st, span(st, pos_in), line_in,
                  slx_pkg::E_NONE};
               n_out = n_out + 3'd1;
            end
            slx_pkg::M_DOT: begin
               res_out[n_out[1:0]] = {slx_pkg::K_NUMBER, st, span(st, dot), line_in,
                  slx_pkg::E_NONE};
               res_out[n_out[1:0] + 2'd1] = {slx_pkg::K_DOT, dot, OFFSET_BITS'(1), line_in,
                  slx_pkg::E_NONE};
               n_out = n_out + 3'd2;
            end
            slx_pkg::M_WORD: begin
               wl = long_in;
               res_out[n_out[1:0]] = {word_kind(word_in, wl), st, span(st, pos_in), line_in,
                  slx_pkg::E_NONE};
               n_out = n_out + 3'd1;
            end
            default: ;
         endcase
         // four tokens at most per transaction, the end token is dropped when full
         if (n_out != 3'd4) begin
            res_out[n_out[1:0]] = {slx_pkg::K_END, pos_in, {OFFSET_BITS{1'b0}}, line_in,
               slx_pkg::E_NONE};
            n_out = n_out + 3'd1;
         end
         mode_in = slx_pkg::M_IDLE;
         pos_in = '0;
         start_in = '0;
         line_in = LINE_BITS'(1);
         word_in = '0;
         long_in = 1'b0;
      end
   end
endmodule

FILE: rtl/slx_back.sv
// back: token queue, drains one token per cycle onto the result channel while out_ready is high
// depends on source_lexer_core_macros.svh
`timescale 1ns / 1ps
`include "source_lexer_core_macros.svh"
module slx_back #(
   parameter int RW = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [2:0] n_in,
   input  logic [3:0][RW-1:0] res_in,
   output logic room,
   output logic out_valid,
   input  logic out_ready,
   output logic [RW:0] out_data
);
   // 8 entries; front may push up to 4 when at most 4 are held
   logic [RW:0] mem [8];
   logic [2:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [3:0] cnt_ff, cnt_in;
   logic pop;
   logic [2:0] n_eff;

   assign pop = out_valid && out_ready;
   assign n_eff = push ? n_in : 3'd0;
   assign room = cnt_ff <= 4'd4;
   assign out_valid = cnt_ff != 4'd0;
   assign out_data = mem[rd_ff];
   assign rd_in = rd_ff + 3'(pop);
   assign wr_in = wr_ff + n_eff;
   assign cnt_in = cnt_ff + 4'(n_eff) - 4'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++)
         if (3'(i) < n_eff)
            mem[wr_ff + 3'(i)] <= {res_in[i], 3'(i) == n_eff - 3'd1};
   end

   `SLX_ASSERT_IMPL(a_no_overflow, clock, reset, push, cnt_ff <= 4'd4)
   `SLX_ASSERT_NEXT(a_count_track, clock, reset, !push && pop, cnt_ff == $past(cnt_ff) - 4'd1)
   `SLX_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, cnt_ff <= 4'd8)
endmodule

FILE: bench/source_lexer_checker.sv
// token predictor and scoreboard for source_lexer_core
// depends on slx_pkg and the channel interfaces in slx_if
`timescale 1ns / 1ps
module source_lexer_checker (
   input logic clock,
   input logic reset,
   slx_req_if req,
   slx_rsp_if rsp,
   output int fail_count,
   output int tokens_due
);
   typedef struct {
      logic [5:0] kind;
      logic [19:0] start;
      logic [19:0] len;
      logic [15:0] line;
      logic [1:0] err;
      logic last;
   } token_type;

   token_type tokens_expected[$];
   token_type fresh[$];

   slx_pkg::mode_type scan;
   logic [19:0] pos, tok_start;
   logic [15:0] line_no;
   logic [47:0] word_tail;
   logic word_long;

   function automatic logic digit_char(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic alpha_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic [19:0] dist_of(input logic [19:0] a, input logic [19:0] b);
      return b >= a ? b - a : 20'd0;
   endfunction

   function automatic void clear_scan();
      scan = slx_pkg::M_IDLE;
      pos = '0;
      tok_start = '0;
      line_no = 16'd1;
      word_tail = '0;
      word_long = 1'b0;
   endfunction

   function automatic void push_token(input logic [5:0] k, input logic [19:0] s,
                                      input logic [19:0] l, input logic [1:0] e);
      token_type t;
      if (fresh.size() >= 4) return;
      t.kind = k;
      t.start = s;
      t.len = l;
      t.line = line_no;
      t.err = e;
      t.last = 1'b0;
      fresh = {fresh, t};
   endfunction

   function automatic void bump_line();
      if (line_no != '1) line_no = line_no + 16'd1;
   endfunction

   function automatic void word_append(input logic [7:0] c);
      if (word_tail[47:40] != 8'h00) word_long = 1'b1;
      word_tail = {word_tail[39:0], c};
   endfunction

   function automatic logic [5:0] word_token();
      if (word_long) return slx_pkg::K_IDENT;
      for (int i = 0; i < 16; i++) begin
         if (slx_pkg::KW_TEXT[i][63:48] == 16'h0 && slx_pkg::KW_TEXT[i][47:0] == word_tail)
            return slx_pkg::K_KEYWORD0 + 6'(i);
      end
      return slx_pkg::K_IDENT;
   endfunction

   function automatic logic [5:0] pair_base(input slx_pkg::mode_type m);
      case (m)
         slx_pkg::M_BANG: return slx_pkg::K_BANG;
         slx_pkg::M_EQUAL: return slx_pkg::K_EQUAL;
         slx_pkg::M_LESS: return slx_pkg::K_LESS;
         default: return slx_pkg::K_GREATER;
      endcase
   endfunction

   function automatic void begin_token(input logic [7:0] c);
      tok_start = pos;
      scan = slx_pkg::M_IDLE;
      case (c)
         "(": push_token(slx_pkg::K_LPAREN, pos, 20'd1, slx_pkg::E_NONE);
         ")": push_token(slx_pkg::K_RPAREN, pos, 20'd1, slx_pkg::E_NONE);
         "{": push_token(slx_pkg::K_LBRACE, pos, 20'd1, slx_pkg::E_NONE);
         "}": push_token(slx_pkg::K_RBRACE, pos, 20'd1, slx_pkg::E_NONE);
         ",": push_token(slx_pkg::K_COMMA, pos, 20'd1, slx_pkg::E_NONE);
         ".": push_token(slx_pkg::K_DOT, pos, 20'd1, slx_pkg::E_NONE);
         "-": push_token(slx_pkg::K_MINUS, pos, 20'd1, slx_pkg::E_NONE);
         "+": push_token(slx_pkg::K_PLUS, pos, 20'd1, slx_pkg::E_NONE);
         ";": push_token(slx_pkg::K_SEMI, pos, 20'd1, slx_pkg::E_NONE);
         "*": push_token(slx_pkg::K_STAR, pos, 20'd1, slx_pkg::E_NONE);
         "!": scan = slx_pkg::M_BANG;
         "=": scan = slx_pkg::M_EQUAL;
         "<": scan = slx_pkg::M_LESS;
         ">": scan = slx_pkg::M_GREATER;
         "/": scan = slx_pkg::M_SLASH;
         8'h22: scan = slx_pkg::M_STRING;
         8'h20, 8'h0d, 8'h09: ;
         8'h0a: bump_line();
         default: begin
            if (digit_char(c)) begin
               scan = slx_pkg::M_INT;
            end else if (alpha_char(c)) begin
               scan = slx_pkg::M_WORD;
               word_tail = '0;
               word_long = 1'b0;
               word_append(c);
            end else begin
               push_token(slx_pkg::K_LPAREN, pos, 20'd1, slx_pkg::E_UNEXPECTED);
            end
         end
      endcase
   endfunction

   function automatic void consume(input logic [7:0] c);
      logic [19:0] dot_at;
      case (scan)
         slx_pkg::M_BANG, slx_pkg::M_EQUAL, slx_pkg::M_LESS, slx_pkg::M_GREATER: begin
            if (c == "=") begin
               push_token(pair_base(scan) + 6'd1, tok_start,
                          dist_of(tok_start, pos) + 20'd1, slx_pkg::E_NONE);
               scan = slx_pkg::M_IDLE;
               return;
            end
            push_token(pair_base(scan), tok_start, 20'd1, slx_pkg::E_NONE);
         end
         slx_pkg::M_SLASH: begin
            if (c == "/") begin
               scan = slx_pkg::M_COMMENT;
               return;
            end
            push_token(slx_pkg::K_SLASH, tok_start, 20'd1, slx_pkg::E_NONE);
         end
         slx_pkg::M_COMMENT: begin
            if (c == 8'h0a) begin
               bump_line();
               scan = slx_pkg::M_IDLE;
            end
            return;
         end
         slx_pkg::M_STRING: begin
            if (c == 8'h22) begin
               push_token(slx_pkg::K_STRING, tok_start, dist_of(tok_start, pos) + 20'd1,
                          slx_pkg::E_NONE);
               scan = slx_pkg::M_IDLE;
            end else if (c == 8'h0a) begin
               bump_line();
            end
            return;
         end
         slx_pkg::M_INT: begin
            if (digit_char(c)) return;
            if (c == ".") begin
               scan = slx_pkg::M_DOT;
               return;
            end
            push_token(slx_pkg::K_NUMBER, tok_start, dist_of(tok_start, pos), slx_pkg::E_NONE);
         end
         slx_pkg::M_DOT: begin
            if (digit_char(c)) begin
               scan = slx_pkg::M_FRAC;
               return;
            end
            dot_at = pos > 0 ? pos - 20'd1 : 20'd0;
            push_token(slx_pkg::K_NUMBER, tok_start, dist_of(tok_start, dot_at),
                       slx_pkg::E_NONE);
            push_token(slx_pkg::K_DOT, dot_at, 20'd1, slx_pkg::E_NONE);
         end
         slx_pkg::M_FRAC: begin
            if (digit_char(c)) return;
            push_token(slx_pkg::K_NUMBER, tok_start, dist_of(tok_start, pos), slx_pkg::E_NONE);
         end
         slx_pkg::M_WORD: begin
            if (digit_char(c) || alpha_char(c)) begin
               word_append(c);
               return;
            end
            push_token(word_token(), tok_start, dist_of(tok_start, pos), slx_pkg::E_NONE);
         end
         default: ;
      endcase
      begin_token(c);
   endfunction

   function automatic void close_source();
      logic [19:0] dot_at;
      logic [19:0] n;
      n = dist_of(tok_start, pos);
      case (scan)
         slx_pkg::M_BANG, slx_pkg::M_EQUAL, slx_pkg::M_LESS, slx_pkg::M_GREATER:
            push_token(pair_base(scan), tok_start, 20'd1, slx_pkg::E_NONE);
         slx_pkg::M_SLASH: push_token(slx_pkg::K_SLASH, tok_start, 20'd1, slx_pkg::E_NONE);
         slx_pkg::M_STRING:
            push_token(slx_pkg::K_LPAREN, tok_start, n, slx_pkg::E_UNTERMINATED);
         slx_pkg::M_INT, slx_pkg::M_FRAC:
            push_token(slx_pkg::K_NUMBER, tok_start, n, slx_pkg::E_NONE);
         slx_pkg::M_DOT: begin
            dot_at = pos > 0 ? pos - 20'd1 : 20'd0;
            push_token(slx_pkg::K_NUMBER, tok_start, dist_of(tok_start, dot_at),
                       slx_pkg::E_NONE);
            push_token(slx_pkg::K_DOT, dot_at, 20'd1, slx_pkg::E_NONE);
         end
         slx_pkg::M_WORD: push_token(word_token(), tok_start, n, slx_pkg::E_NONE);
         default: ;
      endcase
      push_token(slx_pkg::K_END, pos, 20'd0, slx_pkg::E_NONE);
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      token_type w;
      if (reset) begin
         clear_scan();
         tokens_expected.delete();
         fail_count = 0;
      end else begin
         if (req.valid && req.ready) begin
            fresh.delete();
            if (req.has_byte) begin
               consume(req.source_byte);
               if (pos != '1) pos = pos + 20'd1;
            end
            if (req.end_of_source) begin
               close_source();
               clear_scan();
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            tokens_expected = {tokens_expected, fresh};
         end
         if (rsp.valid && rsp.ready) begin
            if (tokens_expected.size() == 0) begin
               report_mismatch("unexpected transaction, kind", rsp.token_kind, -1);
            end else begin
               w = tokens_expected.pop_front();
               if (rsp.token_kind !== w.kind)
                  report_mismatch("token_kind", rsp.token_kind, w.kind);
               if (rsp.start_offset !== w.start)
                  report_mismatch("start_offset", rsp.start_offset, w.start);
               if (rsp.lexeme_length !== w.len)
                  report_mismatch("lexeme_length", rsp.lexeme_length, w.len);
               if (rsp.line_number !== w.line)
                  report_mismatch("line_number", rsp.line_number, w.line);
               if (rsp.error_code !== w.err)
                  report_mismatch("error_code", rsp.error_code, w.err);
               if (rsp.last_result !== w.last)
                  report_mismatch("last_result", rsp.last_result, w.last);
            end
         end
      end
      tokens_due = tokens_expected.size();
   end
endmodule

FILE: bench/testbench.sv
// stimulus and verdict for source_lexer_core
// depends on slx_pkg, slx_if, the core and source_lexer_checker
`timescale 1ns / 1ps
module testbench;
   logic clock;
   logic reset;
   int fail_count;
   int tokens_due;
   int idle_cycles;
   int tokens_taken;
   int bytes_sent;

   // one source byte slot: byte, has_byte, end_of_source
   typedef struct {
      logic [7:0] ch;
      logic has;
      logic eos;
   } slot_type;
   slot_type source_text[$];

   string keywords [16] = '{"and", "class", "else", "false", "fun", "for", "if", "nil",
      "or", "print", "return", "super", "this", "true", "var", "while"};
   string punct = "(){},.-+;*";
   string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string pair_ops = "!=<>";
   string blanks = " \t\r\n";
   string seps = " \n";

   slx_req_if req_ch ();
   slx_rsp_if #(.OFFSET_BITS(20), .LINE_BITS(16)) rsp_ch ();

   source_lexer_core #(.OFFSET_BITS(20), .LINE_BITS(16), .KEYWORD_CHARS(6)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   source_lexer_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .fail_count(fail_count),
      .tokens_due(tokens_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // helpers that build the source text as a list of transactions
   function automatic void put_byte(input logic [7:0] c);
      slot_type s;
      s.ch = c;
      s.has = 1'b1;
      s.eos = 1'b0;
      source_text = {source_text, s};
   endfunction

   function automatic void put_text(input string t);
      for (int i = 0; i < t.len(); i++) put_byte(t[i]);
   endfunction

   // close a source: either a bare end marker or end marker riding on a byte
   function automatic void put_end();
      slot_type s;
      if (source_text.size() > 0 && $urandom_range(0, 1) == 1 && !source_text[$].eos) begin
         source_text[source_text.size() - 1].eos = 1'b1;
      end else begin
         s.ch = 8'($urandom);
         s.has = 1'b0;
         s.eos = 1'b1;
         source_text = {source_text, s};
      end
   endfunction

   // random lexeme, mostly well-formed, some noise
   function automatic void put_lexeme();
      int n;
      case ($urandom_range(0, 13))
         0, 1: put_text(keywords[$urandom_range(0, 15)]);
         2: begin
            // identifier, sometimes longer than the keyword compare width
            put_byte(alnum[$urandom_range(0, 52)]);
            n = $urandom_range(0, 9);
            repeat (n) put_byte(alnum[$urandom_range(0, 62)]);
         end
         3: begin
            // number, optional fraction
            repeat ($urandom_range(1, 4)) put_byte(8'h30 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1) begin
               put_byte(".");
               repeat ($urandom_range(1, 3)) put_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
         end
         4: begin
            // number with a trailing dot that is not a fraction
            repeat ($urandom_range(1, 3)) put_byte(8'h30 + 8'($urandom_range(0, 9)));
            put_byte(".");
         end
         5: begin
            put_byte(pair_ops[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 1) put_byte("=");
         end
         6: put_byte(punct[$urandom_range(0, 9)]);
         7: begin
            // string, may span lines, sometimes left open
            put_byte(8'h22);
            repeat ($urandom_range(0, 6))
               put_byte($urandom_range(0, 5) == 0 ? 8'h0a : 8'($urandom_range(8'h23, 8'h7e)));
            if ($urandom_range(0, 5) != 0) put_byte(8'h22);
         end
         8: begin
            put_text("//");
            repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(8'h20, 8'h7e)));
            put_byte(8'h0a);
         end
         9: put_byte("/");
         10, 11: put_byte(blanks[$urandom_range(0, 3)]);
         12: put_byte(8'($urandom_range(0, 255)));
         default: begin
            // empty transaction, consumes nothing
            slot_type s;
            s.ch = 8'($urandom);
            s.has = 1'b0;
            s.eos = 1'b0;
            source_text = {source_text, s};
         end
      endcase
      if ($urandom_range(0, 2) == 0) put_byte(seps[$urandom_range(0, 1)]);
   endfunction

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 5000) begin
            $display("FAIL source_lexer_core");
            $finish;
         end
      end
   end

   // receiver: random back-pressure, stretches with none, and one long hold to fill the token queue
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      tokens_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (tokens_taken == 60) stall = 300;
         else if ((tokens_taken / 40) % 3 == 1) stall = 0;
         else stall = $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         tokens_taken++;
         @(negedge clock);
      end
   end

   // sender
   initial begin
      int gap;
      bit burst;
      slot_type s;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.source_byte = 8'h00;
      req_ch.has_byte = 1'b0;
      req_ch.end_of_source = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: all punctuation, all operators but a lone =, comment, open string, trailing dot
      put_text("(){},.-+;*/ !!=a==<<=>>=//c\n\"s\n\"12.5 3.x and whilez");
      put_byte(8'h00);
      put_byte(8'hff);
      put_end();
      put_text("\"open");
      put_end();
      put_text("7.");
      put_end();

      bytes_sent = 0;
      while (source_text.size() < 420) begin
         repeat ($urandom_range(4, 16)) put_lexeme();
         put_end();
      end

      burst = 1'b0;
      foreach (source_text[i]) begin
         s = source_text[i];
         if (i % 50 == 0) burst = ($urandom_range(0, 2) == 0);
         gap = burst ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.source_byte <= s.ch;
         req_ch.has_byte <= s.has;
         req_ch.end_of_source <= s.eos;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         bytes_sent++;
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;

      while (tokens_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && tokens_due == 0) begin
         $display("PASS source_lexer_core");
      end else begin
         $display("FAIL source_lexer_core");
      end
      $finish;
   end
endmodule
